// ===== src/token_bucket_packet_shaper_core_defines.svh =====
// Assertion macros shared by the token bucket shaper RTL.
`ifndef TOKEN_BUCKET_PACKET_SHAPER_CORE_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define TBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define TBPS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TBPS_ASSERT(lbl, prop, msg)
`define TBPS_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/tbps_pkg.sv =====
// Types and constants of the token bucket packet shaper.
package tbps_pkg;

  localparam int TokW = 10;
  localparam int TagW = 16;

  localparam logic [TokW-1:0] DEPTH_RESET = 10'd10;

  localparam logic [2:0] EV_QUEUED  = 3'd0;
  localparam logic [2:0] EV_FORWARD = 3'd1;
  localparam logic [2:0] EV_TOO_BIG = 3'd2;
  localparam logic [2:0] EV_TOKEN   = 3'd3;
  localparam logic [2:0] EV_LOST    = 3'd4;
  localparam logic [2:0] EV_QFULL   = 3'd5;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic            operation;
    logic [TagW-1:0] packet_tag;
    logic [TokW-1:0] tokens_needed;
  } item_t;

  typedef struct packed {
    logic [2:0]      event_res;
    logic            forward_valid;
    logic [TagW-1:0] forward_tag;
    logic [TokW-1:0] tokens_held;
    logic [6:0]      queue_level;
  } result_t;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [TokW-1:0] need;
  } queue_entry_t;

  typedef struct packed {
    logic read;
    logic push;
    logic pop;
  } queue_cmd_t;

endpackage

// ===== src/tbps_ram.sv =====
// Generic simple dual port RAM with registered read.
module tbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/tbps_queue.sv =====
// Waiting packet queue: head, tail and fill count around one RAM.
`include "token_bucket_packet_shaper_core_defines.svh"

module tbps_queue #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tbps_pkg::queue_cmd_t         cmd,
  input  tbps_pkg::queue_entry_t       wr_entry,
  output tbps_pkg::queue_entry_t       head_entry,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [CW-1:0] count_next;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (cmd.push) begin
      tail_next  = (tail == LastSlot) ? '0 : tail + AW'(1);
      count_next = count + CW'(1);
    end
    if (cmd.pop) begin
      head_next  = (head == LastSlot) ? '0 : head + AW'(1);
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // The head entry is read when an item is taken; any push has already been written by then.
  tbps_ram #(
    .WIDTH($bits(tbps_pkg::queue_entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.push),
    .wr_addr(tail),
    .wr_data(wr_entry),
    .rd_en  (cmd.read),
    .rd_addr(head),
    .rd_data(head_entry)
  );

  `TBPS_NEVER(a_push_pop, cmd.push && cmd.pop, "queue push and pop in the same cycle")
  `TBPS_ASSERT(a_count_max, count <= CW'(DEPTH), "queue count above depth")
  `TBPS_ASSERT(a_push_room, cmd.push |-> count < CW'(DEPTH), "push into a full queue")

endmodule

// ===== src/token_bucket_packet_shaper_core.sv =====
// Channel | signals                          | item
// --------+----------------------------------+-----------------------------------------
// input   | item_valid, item_stall, item     | tick or packet arrival (tbps_pkg::item_t)
// output  | result_valid, result_stall, result | one outcome per item (tbps_pkg::result_t)
// config  | cfg_write, cfg_data              | bucket depth, 10 bits
//
// Each item is taken in IDLE, which also reads the queue head from RAM; EXEC then
// decides, updates the bucket and queue, and loads the output register.
// The output register lets the next item be taken while a result waits; a stalled
// result holds the decide cycle until the register frees up.
// Reset is synchronous; it empties the bucket and queue and sets the depth to 10.
`include "token_bucket_packet_shaper_core_defines.svh"

module token_bucket_packet_shaper_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tbps_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tbps_pkg::result_t result,
  input  logic              cfg_write,
  input  logic [9:0]        cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tbps_pkg::state_t       state;
  tbps_pkg::state_t       state_next;
  tbps_pkg::item_t        cur;
  tbps_pkg::result_t      result_next;
  tbps_pkg::queue_cmd_t   cmd;
  tbps_pkg::queue_entry_t head_entry;
  tbps_pkg::queue_entry_t wr_entry;
  logic [CW-1:0]          count;
  logic [CW-1:0]          level_after;
  logic [9:0]             depth;
  logic [9:0]             tokens;
  logic [9:0]             tokens_next;
  logic [9:0]             tok_inc;
  logic [2:0]             ev;
  logic                   fwd;
  logic [15:0]            ftag;
  logic                   push;
  logic                   pop;
  logic                   q_empty;
  logic                   q_full;
  logic                   accept;
  logic                   load;

  assign q_empty    = (count == '0);
  assign q_full     = (count == CW'(QUEUE_DEPTH));
  assign item_stall = (state != tbps_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign load       = (state == tbps_pkg::ST_EXEC) && (!result_valid || !result_stall);
  assign tok_inc    = tokens + 10'd1;
  assign wr_entry   = '{tag: cur.packet_tag, need: cur.tokens_needed};

  // Decide the outcome of the held item against bucket, queue and head entry.
  always_comb begin
    ev          = tbps_pkg::EV_QUEUED;
    fwd         = 1'b0;
    ftag        = '0;
    tokens_next = tokens;
    push        = 1'b0;
    pop         = 1'b0;
    if (cur.operation) begin
      if (cur.tokens_needed > depth) begin
        ev = tbps_pkg::EV_TOO_BIG;
      end else if (q_empty && cur.tokens_needed <= tokens) begin
        tokens_next = tokens - cur.tokens_needed;
        fwd         = 1'b1;
        ftag        = cur.packet_tag;
        ev          = tbps_pkg::EV_FORWARD;
      end else if (q_full) begin
        ev = tbps_pkg::EV_QFULL;
      end else begin
        push = 1'b1;
        ev   = tbps_pkg::EV_QUEUED;
      end
    end else begin
      if (tokens >= depth) begin
        ev = tbps_pkg::EV_LOST;
      end else if (!q_empty && head_entry.need <= tok_inc) begin
        tokens_next = tok_inc - head_entry.need;
        fwd         = 1'b1;
        ftag        = head_entry.tag;
        pop         = 1'b1;
        ev          = tbps_pkg::EV_FORWARD;
      end else begin
        tokens_next = tok_inc;
        ev          = tbps_pkg::EV_TOKEN;
      end
    end
    level_after = count + CW'(push) - CW'(pop);
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    result_next = result;
    unique case (state)
      tbps_pkg::ST_IDLE: begin
        cmd.read = accept;
        if (accept) begin
          state_next = tbps_pkg::ST_EXEC;
        end
      end
      tbps_pkg::ST_EXEC: begin
        if (load) begin
          cmd.push    = push;
          cmd.pop     = pop;
          result_next = '{event_res: ev, forward_valid: fwd, forward_tag: ftag,
                          tokens_held: tokens_next, queue_level: 7'(level_after)};
          state_next  = tbps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tbps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tbps_pkg::ST_IDLE;
      result_valid <= 1'b0;
      tokens       <= '0;
      depth        <= tbps_pkg::DEPTH_RESET;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        depth <= cfg_data;
      end
      if (load) begin
        tokens       <= tokens_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    result <= result_next;
  end

  tbps_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_entry  (wr_entry),
    .head_entry(head_entry),
    .count     (count)
  );

  `TBPS_ASSERT(a_take_exec, accept |=> state == tbps_pkg::ST_EXEC, "item taken outside idle")
  `TBPS_ASSERT(a_load_done, (state == tbps_pkg::ST_EXEC) && !result_valid |=> (state == tbps_pkg::ST_IDLE) && result_valid, "decide cycle did not load the result")
  `TBPS_ASSERT(a_fwd_code, result_valid |-> (result.forward_valid == (result.event_res == tbps_pkg::EV_FORWARD)), "forward flag disagrees with event")
  `TBPS_ASSERT(a_fwd_tag, result_valid && !result.forward_valid |-> result.forward_tag == '0, "tag set without forward")

endmodule

// ===== tb/token_bucket_packet_shaper_core_checker.sv =====
// Checker for the token bucket shaper: tracks the bucket and waiting queue and scores every result.
`timescale 1ns / 1ps

module token_bucket_packet_shaper_core_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  tbps_pkg::item_t     item,
  input  logic                result_valid,
  input  logic                result_stall,
  input  tbps_pkg::result_t   result,
  input  logic                cfg_write,
  input  logic [9:0]          cfg_data,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int QDEPTH = 64;

  logic [tbps_pkg::TokW-1:0] bucket_depth;
  logic [tbps_pkg::TokW-1:0] tokens;
  logic [tbps_pkg::TagW-1:0] wait_tag [QDEPTH];
  logic [tbps_pkg::TokW-1:0] wait_need [QDEPTH];
  int                        head_slot;
  int                        tail_slot;
  int                        waiting;
  int                        mismatch_total = 0;
  tbps_pkg::result_t         outcome_q [$];
  tbps_pkg::result_t         want;

  assign mismatches = mismatch_total;

  task automatic shape_item(input tbps_pkg::item_t it, output tbps_pkg::result_t r);
    r = '0;
    if (it.operation) begin
      if (it.tokens_needed > bucket_depth) begin
        r.event_res = tbps_pkg::EV_TOO_BIG;
      end else if (waiting == 0 && it.tokens_needed <= tokens) begin
        tokens = tokens - it.tokens_needed;
        r.event_res     = tbps_pkg::EV_FORWARD;
        r.forward_valid = 1'b1;
        r.forward_tag   = it.packet_tag;
      end else if (waiting >= QDEPTH) begin
        r.event_res = tbps_pkg::EV_QFULL;
      end else begin
        wait_tag[tail_slot]  = it.packet_tag;
        wait_need[tail_slot] = it.tokens_needed;
        tail_slot = (tail_slot + 1) % QDEPTH;
        waiting++;
        r.event_res = tbps_pkg::EV_QUEUED;
      end
    end else begin
      if (tokens >= bucket_depth) begin
        r.event_res = tbps_pkg::EV_LOST;
      end else begin
        tokens = tokens + 1'b1;
        r.event_res = tbps_pkg::EV_TOKEN;
        // Only the head may leave, and only one packet per tick.
        if (waiting != 0 && wait_need[head_slot] <= tokens) begin
          tokens = tokens - wait_need[head_slot];
          r.event_res     = tbps_pkg::EV_FORWARD;
          r.forward_valid = 1'b1;
          r.forward_tag   = wait_tag[head_slot];
          head_slot = (head_slot + 1) % QDEPTH;
          waiting--;
        end
      end
    end
    r.tokens_held = tokens;
    r.queue_level = waiting[6:0];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bucket_depth = tbps_pkg::DEPTH_RESET;
      tokens       = '0;
      head_slot    = 0;
      tail_slot    = 0;
      waiting      = 0;
      outcome_q.delete();
    end else begin
      // Score the outgoing result before logging the incoming item of the same edge.
      if (result_valid && !result_stall) begin
        if (outcome_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t unexpected result: ev=%0d fv=%0d tag=%h tokens=%0d level=%0d",
                     $realtime, result.event_res, result.forward_valid, result.forward_tag,
                     result.tokens_held, result.queue_level);
        end else begin
          want = outcome_q.pop_front();
          if (result.event_res !== want.event_res || result.forward_valid !== want.forward_valid ||
              result.forward_tag !== want.forward_tag || result.tokens_held !== want.tokens_held ||
              result.queue_level !== want.queue_level) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("%0t result mismatch: expected ev=%0d fv=%0d tag=%h tokens=%0d level=%0d, got ev=%0d fv=%0d tag=%h tokens=%0d level=%0d",
                       $realtime, want.event_res, want.forward_valid, want.forward_tag,
                       want.tokens_held, want.queue_level, result.event_res,
                       result.forward_valid, result.forward_tag, result.tokens_held,
                       result.queue_level);
          end
        end
      end
      if (cfg_write)
        bucket_depth = cfg_data;
      if (item_valid && !item_stall) begin
        shape_item(item, want);
        outcome_q.push_back(want);
      end
    end
    outstanding <= outcome_q.size();
  end

endmodule

// ===== tb/token_bucket_packet_shaper_core_tb.sv =====
// Testbench top for the token bucket shaper: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 1ps

module token_bucket_packet_shaper_core_tb;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  localparam int MIX_BALANCED = 0;
  localparam int MIX_BACKLOG  = 1;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  tbps_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  tbps_pkg::result_t result;
  logic              cfg_write;
  logic [9:0]        cfg_data;
  int                mismatches;
  int                outstanding;

  int idle_mode     = IDLE_NONE;
  bit long_hold_req = 1'b0;
  bit hold_served   = 1'b0;

  token_bucket_packet_shaper_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  token_bucket_packet_shaper_core_checker shaper_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls per phase, plus one long hold-off to back the block up.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_served) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_served = 1'b1;
      end else if (idle_mode == IDLE_RECV) begin
        result_stall <= ($urandom_range(99) < 88);
      end else if (idle_mode == IDLE_BOTH) begin
        result_stall <= ($urandom_range(99) < 32);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic tbps_pkg::item_t tick_item();
    tbps_pkg::item_t it;
    it.operation     = 1'b0;
    it.packet_tag    = 16'($urandom);
    it.tokens_needed = 10'($urandom);
    return it;
  endfunction

  function automatic tbps_pkg::item_t packet_item(input logic [15:0] tag,
                                                  input logic [9:0] need);
    tbps_pkg::item_t it;
    it.operation     = 1'b1;
    it.packet_tag    = tag;
    it.tokens_needed = need;
    return it;
  endfunction

  function automatic tbps_pkg::item_t random_item(input int mix, input logic [9:0] depth_now);
    tbps_pkg::item_t it;
    int              roll;
    it.packet_tag    = 16'($urandom);
    it.tokens_needed = 10'($urandom);
    roll = $urandom_range(9);
    if (mix == MIX_BACKLOG) begin
      // Mostly costly packets, so the queue fills and overflows.
      it.operation     = ($urandom_range(99) >= 12);
      it.tokens_needed = 10'($urandom_range(1023, 1));
    end else begin
      it.operation = ($urandom_range(99) >= 60);
      if (depth_now > 16)
        it.tokens_needed = 10'($urandom_range(2));
      else if (roll != 0)
        it.tokens_needed = 10'($urandom_range(depth_now));
    end
    return it;
  endfunction

  task automatic offer_item(input tbps_pkg::item_t it);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 88 : (idle_mode == IDLE_BOTH) ? 32 : 0;
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // The count of open items is registered in the checker; settle waits until it reads zero.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(input logic [9:0] depth);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= depth;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input logic [9:0] depth, input int mode, input int count,
                           input int mix, input bit hold);
    write_depth(depth);
    idle_mode = mode;
    if (hold)
      long_hold_req = 1'b1;
    repeat (count) offer_item(random_item(mix, depth));
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset depth of ten: empty-bucket forward, oversize drops, fill and overflow the bucket.
    offer_item(packet_item(16'h0000, 10'd0));
    offer_item(packet_item(16'hFFFF, 10'd1023));
    offer_item(packet_item(16'h1234, 10'd11));
    repeat (10) offer_item(tick_item());
    offer_item(tick_item());
    offer_item(packet_item(16'hABCD, 10'd10));
    // A head that cannot pay holds back a free packet behind it.
    offer_item(packet_item(16'h00FF, 10'd3));
    offer_item(packet_item(16'hFF00, 10'd0));
    repeat (2) offer_item(tick_item());
    offer_item(tick_item());
    offer_item(tick_item());

    // Depth of zero, written below the current count: ticks are lost, only free packets pass.
    write_depth(10'd0);
    offer_item(tick_item());
    offer_item(packet_item(16'h5A5A, 10'd0));
    offer_item(packet_item(16'hA5A5, 10'd1));

    // Depths only grow from here, so a queued head can always be paid eventually.
    run_phase(10'd1,    IDLE_SEND, 120, MIX_BALANCED, 1'b0);
    run_phase(10'd5,    IDLE_NONE, 100, MIX_BALANCED, 1'b0);
    run_phase(10'd16,   IDLE_RECV, 120, MIX_BALANCED, 1'b0);
    run_phase(10'd40,   IDLE_NONE,  60, MIX_BALANCED, 1'b1);
    run_phase(10'd1023, IDLE_BOTH, 120, MIX_BALANCED, 1'b0);
    run_phase(10'd1023, IDLE_BOTH, 100, MIX_BACKLOG,  1'b0);
    run_phase(10'd1023, IDLE_RECV, 100, MIX_BACKLOG,  1'b0);

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tbps_pkg.sv
src/tbps_ram.sv
src/tbps_queue.sv
src/token_bucket_packet_shaper_core.sv
tb/token_bucket_packet_shaper_core_checker.sv
tb/token_bucket_packet_shaper_core_tb.sv
